>>> hw/rtl/plst_pkg.sv
// Shared types, codes and microprogram of the positional list store.
package plst_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int POS_W        = 16;
    localparam int VAL_W        = 32;
    localparam int COUNT_OUT_W  = 9;
    localparam int BIT_CNT_W    = $clog2(POS_W);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [3:0] step_t;

    // Microprogram addresses
    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_CHECK_OP = 4'd1;
    localparam step_t S_PREP     = 4'd2;
    localparam step_t S_DIV      = 4'd3;
    localparam step_t S_WRAP     = 4'd4;
    localparam step_t S_RD_ISSUE = 4'd5;
    localparam step_t S_RD_TAKE  = 4'd6;
    localparam step_t S_RM_READ  = 4'd7;
    localparam step_t S_RM_WRITE = 4'd8;
    localparam step_t S_RM_END   = 4'd9;
    localparam step_t S_IN_READ  = 4'd10;
    localparam step_t S_IN_WRITE = 4'd11;
    localparam step_t S_IN_PUT   = 4'd12;
    localparam step_t S_RESULT   = 4'd15;

    typedef enum logic [3:0] {
        D_NOP,
        D_LOAD,
        D_PREP,
        D_DIV,
        D_WRAP,
        D_RD_IDX,
        D_TAKE,
        D_RD_NEXT,
        D_WR_DOWN,
        D_RD_PREV,
        D_WR_UP,
        D_PUT,
        D_DEC,
        D_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_OP_BAD,
        C_REFUSE,
        C_DIV_MORE,
        C_INSERT,
        C_PEEK,
        C_RM_DONE,
        C_INS_DONE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t dp;
        cond_t  cond;
        step_t  target;
    } uword_t;

    typedef struct packed {
        logic no_input;
        logic op_bad;
        logic refuse;
        logic div_more;
        logic is_insert;
        logic is_peek;
        logic rm_done;
        logic ins_done;
        logic out_busy;
    } dp_flags_t;

    // Control store: one word per step, jump to target when cond holds.
    // The result step sits at the top address so that falling through
    // wraps back to dispatch.
    function automatic uword_t ucode_rom(input step_t addr);
        uword_t w;
        unique case (addr)
            S_IDLE:     w = '{D_LOAD,    C_NO_INPUT, S_IDLE};
            S_CHECK_OP: w = '{D_NOP,     C_OP_BAD,   S_RESULT};
            S_PREP:     w = '{D_PREP,    C_REFUSE,   S_RESULT};
            S_DIV:      w = '{D_DIV,     C_DIV_MORE, S_DIV};
            S_WRAP:     w = '{D_WRAP,    C_INSERT,   S_IN_READ};
            S_RD_ISSUE: w = '{D_RD_IDX,  C_NEXT,     S_IDLE};
            S_RD_TAKE:  w = '{D_TAKE,    C_PEEK,     S_RESULT};
            S_RM_READ:  w = '{D_RD_NEXT, C_RM_DONE,  S_RM_END};
            S_RM_WRITE: w = '{D_WR_DOWN, C_ALWAYS,   S_RM_READ};
            S_RM_END:   w = '{D_DEC,     C_ALWAYS,   S_RESULT};
            S_IN_READ:  w = '{D_RD_PREV, C_INS_DONE, S_IN_PUT};
            S_IN_WRITE: w = '{D_WR_UP,   C_ALWAYS,   S_IN_READ};
            S_IN_PUT:   w = '{D_PUT,     C_ALWAYS,   S_RESULT};
            S_RESULT:   w = '{D_RESULT,  C_OUT_BUSY, S_RESULT};
            default:    w = '{D_NOP,     C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/plst_useq.sv
// Microsequencer: step counter, control store and jump logic.
module plst_useq (
    input  logic               clk,
    input  logic               rst_n,
    input  plst_pkg::dp_flags_t flags,
    output plst_pkg::dp_op_t   dp_op
);
    import plst_pkg::*;

    step_t  upc_reg;
    step_t  upc_next;
    uword_t word;
    logic   taken;

    assign word  = ucode_rom(upc_reg);
    assign dp_op = word.dp;

    always_comb
    begin
        unique case (word.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_INPUT: taken = flags.no_input;
            C_OP_BAD:   taken = flags.op_bad;
            C_REFUSE:   taken = flags.refuse;
            C_DIV_MORE: taken = flags.div_more;
            C_INSERT:   taken = flags.is_insert;
            C_PEEK:     taken = flags.is_peek;
            C_RM_DONE:  taken = flags.rm_done;
            C_INS_DONE: taken = flags.ins_done;
            C_OUT_BUSY: taken = flags.out_busy;
            default:    taken = 1'b0;
        endcase
        upc_next = taken ? word.target : step_t'(upc_reg + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> hw/rtl/plst_datapath.sv
// Datapath: item registers, element memory, position divider, result register.
module plst_datapath #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plst_pkg::dp_op_t                    dp_op,
    output plst_pkg::dp_flags_t                 flags,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic signed [plst_pkg::POS_W-1:0]   position,
    input  logic signed [plst_pkg::VAL_W-1:0]   item_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [plst_pkg::VAL_W-1:0]   read_value,
    output logic [plst_pkg::COUNT_OUT_W-1:0]    count,
    output logic [1:0]                          status
);
    import plst_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [VAL_W-1:0]     mem [CAPACITY];
    logic [VAL_W-1:0]     mem_q;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [VAL_W-1:0]     wr_data;
    logic                 wr_en;

    logic [1:0]           op_reg;
    logic                 neg_reg;
    logic [POS_W-1:0]     mag_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [VAL_W-1:0]     rd_reg;
    logic [1:0]           st_reg;
    logic [CNT_W-1:0]     count_reg;

    logic                 out_valid_reg;
    logic [VAL_W-1:0]     out_value_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [1:0]           out_status_reg;

    logic                 is_insert;
    logic                 full;
    logic                 empty;
    logic                 accept;
    logic [CNT_W:0]       div_shift;
    logic [CNT_W:0]       div_diff;
    logic [CNT_W-1:0]     wrapped;
    logic [CNT_W:0]       ptr_plus;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    assign is_insert = (op_reg == OP_INSERT);
    assign full      = (count_reg == CAP_CNT);
    assign empty     = (count_reg == '0);
    assign accept    = (dp_op == D_LOAD) && in_valid;
    assign in_stall  = (dp_op != D_LOAD);

    // One restoring division step per cycle
    assign div_shift = {rem_reg, mag_reg[POS_W-1]};
    assign div_diff  = div_shift - {1'b0, len_reg};
    assign wrapped   = (neg_reg && rem_reg != '0) ? CNT_W'(len_reg - rem_reg) : rem_reg;
    assign ptr_plus  = (CNT_W+1)'(ptr_reg) + (CNT_W+1)'(1);

    always_comb
    begin
        flags.no_input  = !in_valid;
        flags.op_bad    = (op_reg != OP_INSERT) && (op_reg != OP_REMOVE)
                          && (op_reg != OP_PEEK);
        flags.refuse    = is_insert ? full : empty;
        flags.div_more  = (bit_cnt_reg != '0);
        flags.is_insert = is_insert;
        flags.is_peek   = (op_reg == OP_PEEK);
        flags.rm_done   = (ptr_plus >= {1'b0, count_reg});
        flags.ins_done  = (ptr_reg == idx_reg);
        flags.out_busy  = out_valid_reg && out_stall;
    end

    always_comb
    begin
        rd_addr = idx_reg;
        wr_addr = ptr_reg;
        wr_data = mem_q;
        wr_en   = 1'b0;
        case (dp_op)
            D_RD_NEXT: rd_addr = ADDR_W'(ptr_plus);
            D_RD_PREV: rd_addr = ptr_reg - ADDR_W'(1);
            D_WR_DOWN, D_WR_UP: wr_en = 1'b1;
            D_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = val_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (dp_op)
            D_LOAD:
            begin
                if (accept)
                begin
                    op_reg  <= opcode;
                    neg_reg <= position[POS_W-1];
                    mag_reg <= position[POS_W-1] ? POS_W'(~position + POS_W'(1))
                                                 : position;
                    val_reg <= item_value;
                    rd_reg  <= '0;
                    st_reg  <= ST_OK;
                end
            end
            D_PREP:
            begin
                len_reg     <= is_insert ? CNT_W'(count_reg + CNT_W'(1)) : count_reg;
                rem_reg     <= '0;
                bit_cnt_reg <= BIT_CNT_W'(POS_W - 1);
                if (is_insert && full)
                begin
                    st_reg <= ST_FULL;
                end
                else if (!is_insert && empty)
                begin
                    st_reg <= ST_EMPTY;
                end
            end
            D_DIV:
            begin
                rem_reg     <= div_diff[CNT_W] ? div_shift[CNT_W-1:0] : div_diff[CNT_W-1:0];
                mag_reg     <= {mag_reg[POS_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
            end
            D_WRAP:
            begin
                idx_reg <= wrapped[ADDR_W-1:0];
                ptr_reg <= is_insert ? count_reg[ADDR_W-1:0] : wrapped[ADDR_W-1:0];
            end
            D_TAKE:    rd_reg  <= mem_q;
            D_WR_DOWN: ptr_reg <= ADDR_W'(ptr_plus);
            D_WR_UP:   ptr_reg <= ptr_reg - ADDR_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dp_op == D_PUT)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (dp_op == D_DEC)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_op == D_RESULT && !flags.out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_op == D_RESULT && !flags.out_busy)
        begin
            out_value_reg  <= rd_reg;
            out_count_reg  <= count_wide[COUNT_OUT_W-1:0];
            out_status_reg <= st_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign count      = out_count_reg;
    assign status     = out_status_reg;

endmodule

>>> hw/rtl/positional_list_store.sv
// The time from the accepting edge to the result grows with the number of moved entries;
// a remove at position 0 of a full store is the slowest case. A refused item and an
// unused opcode go straight from the checks to the result.
// One item is in work at a time; the next item can be taken in the cycle a result shows.
// The 16-step position divider and a read then a write per moved entry set the time.
// Reset clears the count, sequencer and output valid; element memory is not cleared.
module positional_list_store #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic signed [plst_pkg::POS_W-1:0]   position,
    input  logic signed [plst_pkg::VAL_W-1:0]   item_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [plst_pkg::VAL_W-1:0]   read_value,
    output logic [plst_pkg::COUNT_OUT_W-1:0]    count,
    output logic [1:0]                          status
);
    import plst_pkg::*;

    dp_op_t    dp_op;
    dp_flags_t flags;

    plst_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .dp_op (dp_op)
    );

    plst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_op      (dp_op),
        .flags      (flags),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

endmodule

>>> hw/rtl/plst_checker.sv
// Port-level checks on the positional list store, bound to its top level.
module plst_checker #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [1:0]                          opcode,
    input logic signed [plst_pkg::POS_W-1:0]   position,
    input logic signed [plst_pkg::VAL_W-1:0]   item_value,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [plst_pkg::VAL_W-1:0]   read_value,
    input logic [plst_pkg::COUNT_OUT_W-1:0]    count,
    input logic [1:0]                          status
);
    import plst_pkg::*;

    localparam logic [COUNT_OUT_W-1:0] CAP_OUT = COUNT_OUT_W'(CAPACITY);

    // Hold a stalled item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(position)
            && $stable(item_value))
        else $error("stalled item changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value)
            && $stable(count) && $stable(status))
        else $error("stalled result changed");

    // Empty status only with nothing stored and no value
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0 && read_value == '0)
        else $error("empty status with data");

    // Full status only at capacity and with no value
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == CAP_OUT && read_value == '0)
        else $error("full status below capacity");

    // No new result in the cycle after an item is taken, unless a stalled result is held
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !(out_valid && out_stall) |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind positional_list_store plst_checker #(.CAPACITY(CAPACITY)) u_plst_checker (.*);

>>> verif/tb_positional_list_store.sv
// Self-checking testbench for the positional list store: directed and random list operations.
`timescale 1ns / 1ps

module tb_positional_list_store;
    import plst_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS = 480;

    typedef struct {
        logic signed [VAL_W-1:0]   rd_val;
        logic [COUNT_OUT_W-1:0]    cnt;
        logic [1:0]                st;
    } list_result_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = OP_PEEK;
    logic signed [POS_W-1:0] position = '0;
    logic signed [VAL_W-1:0] item_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0] count;
    logic [1:0] status;

    // Shadow copy of the stored sequence and the results still owed by the block
    logic signed [VAL_W-1:0] list_vals[$];
    list_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int peak_occupancy = 0;
    int full_refusals = 0;
    int empty_hits = 0;

    positional_list_store #(.CAPACITY(LIST_CAP)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Truncating modulo, then fold a negative remainder back into [0, len)
    function automatic int wrap_index(input logic signed [POS_W-1:0] pos, input int len);
        int mag;
        int rem;
        mag = (pos < 0) ? -int'(pos) : int'(pos);
        rem = mag % len;
        if (pos < 0 && rem != 0)
            return len - rem;
        return rem;
    endfunction

    function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic signed [VAL_W-1:0] val);
        list_result_t r;
        int idx;
        r.rd_val = '0;
        r.st = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (list_vals.size() >= LIST_CAP)
                    r.st = ST_FULL;
                else
                begin
                    idx = wrap_index(pos, list_vals.size() + 1);
                    list_vals.insert(idx, val);
                end
            end
            OP_REMOVE:
            begin
                if (list_vals.size() == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    idx = wrap_index(pos, list_vals.size());
                    r.rd_val = list_vals[idx];
                    list_vals.delete(idx);
                end
            end
            OP_PEEK:
            begin
                if (list_vals.size() == 0)
                    r.st = ST_EMPTY;
                else
                    r.rd_val = list_vals[wrap_index(pos, list_vals.size())];
            end
            default: ;
        endcase
        r.cnt = COUNT_OUT_W'(list_vals.size());
        return r;
    endfunction

    // Drive one item, hold it through stalls, and record the expected result once taken
    task automatic send_item(input logic [1:0] op, input logic signed [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val);
        list_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        position   <= pos;
        item_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_list_op(op, pos, val);
        pending_results.push_back(r);
        items_sent++;
        if (r.st == ST_FULL)
            full_refusals++;
        if (r.st == ST_EMPTY)
            empty_hits++;
        if (list_vals.size() > peak_occupancy)
            peak_occupancy = list_vals.size();
    endtask

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: read_value %0d count %0d status %0d",
                       read_value, count, status);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (read_value !== exp_r.rd_val)
                begin
                    $error("read_value: expected %0d, got %0d", exp_r.rd_val, read_value);
                    fail_count++;
                end
                if (count !== exp_r.cnt)
                begin
                    $error("count: expected %0d, got %0d", exp_r.cnt, count);
                    fail_count++;
                end
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, status);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [POS_W-1:0] pick_position();
        int n;
        n = list_vals.size();
        case ($urandom_range(0, 3))
            0: return POS_W'($urandom_range(0, n + 1));
            1: return POS_W'(-int'($urandom_range(1, n + 1)));
            2: return POS_W'($urandom());
            default: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_list();
        send_item(OP_PEEK, 16'sd0, 32'sd5);
        send_item(OP_REMOVE, 16'sh8000, 32'sd0);
        send_item(OP_REMOVE, 16'sh7fff, -32'sd1);
        send_item(OP_PEEK, -16'sd1, 32'sd0);
        send_item(OP_UNUSED, 16'sh7fff, 32'sh7fff_ffff);
    endtask

    task automatic test_small_list();
        send_item(OP_INSERT, 16'sh7fff, 32'sh7fff_ffff);
        send_item(OP_PEEK, 16'sh8000, 32'sd0);
        // wrap -1 against the new length: append at the tail
        send_item(OP_INSERT, -16'sd1, 32'sh8000_0000);
        send_item(OP_INSERT, 16'sd0, 32'sd0);
        send_item(OP_INSERT, 16'sd3, -32'sd1);
        send_item(OP_INSERT, 16'sd2, 32'sh5a5a_a5a5);
        send_item(OP_PEEK, -16'sd1, 32'sd0);
        send_item(OP_PEEK, 16'sd4, 32'sd0);
        send_item(OP_UNUSED, 16'sh8000, 32'sh8000_0000);
        send_item(OP_REMOVE, 16'sh7fff, 32'sd0);
        send_item(OP_REMOVE, 16'sh8000, 32'sd0);
        send_item(OP_REMOVE, -16'sd2, 32'sd0);
        send_item(OP_PEEK, 16'sd1, 32'sd0);
        send_item(OP_REMOVE, 16'sd0, 32'sd0);
        send_item(OP_REMOVE, 16'sd1, 32'sd0);
        send_item(OP_REMOVE, 16'sd0, 32'sd0);
    endtask

    task automatic test_full_store();
        while (list_vals.size() < LIST_CAP)
            send_item(OP_INSERT, pick_position(), pick_value());
        send_item(OP_INSERT, 16'sd0, 32'sd1);
        send_item(OP_INSERT, 16'sh7fff, 32'sd2);
        send_item(OP_PEEK, -16'sd1, 32'sd0);
        send_item(OP_PEEK, 16'sh8000, 32'sd0);
        send_item(OP_REMOVE, 16'(LIST_CAP - 1), 32'sd0);
        // position equal to the old count appends
        send_item(OP_INSERT, 16'(LIST_CAP - 1), 32'sh1234_5678);
        send_item(OP_UNUSED, 16'sd0, 32'sd0);
        send_item(OP_INSERT, -16'sd1, 32'sd3);
        send_item(OP_REMOVE, 16'sd0, 32'sd0);
        while (list_vals.size() > 16)
            send_item(OP_REMOVE, pick_position(), 32'sd0);
    endtask

    task automatic test_random_mix(input int n_items, input int send_pct, input int recv_pct);
        logic [1:0] op;
        int r;
        int ins_weight;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            ins_weight = (list_vals.size() < 48) ? 44 : 34;
            if (r < 3)
                op = OP_UNUSED;
            else if (r < 20)
                op = OP_PEEK;
            else if ($urandom_range(0, 79) < ins_weight)
                op = OP_INSERT;
            else
                op = OP_REMOVE;
            send_item(op, pick_position(), pick_value());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 47;
        test_empty_list();
        test_small_list();
        test_full_store();
        test_random_mix(RANDOM_ITEMS / 3, 21, 47);
        test_random_mix(RANDOM_ITEMS / 3, 47, 21);
        test_random_mix(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // let a stray late result show up
        repeat (2 * LIST_CAP + 100) @(posedge clk);

        $display("%0d items sent, %0d results checked; peak occupancy %0d of %0d",
                 items_sent, results_checked, peak_occupancy, LIST_CAP);
        $display("%0d refused inserts on a full store, %0d operations on an empty list",
                 full_refusals, empty_hits);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/plst_pkg.sv
hw/rtl/plst_useq.sv
hw/rtl/plst_datapath.sv
hw/rtl/positional_list_store.sv
hw/rtl/plst_checker.sv
verif/tb_positional_list_store.sv
